// ===== sv/olie_pkg.sv =====
// ----------------------------------------------------------------------------
// olie_pkg: shared types and codes of the ordered list engine
// Holds the transfer payloads, the operation and status codes, and the
// control groups passed between the list cells, the search unit and the top.
// ----------------------------------------------------------------------------
package olie_pkg;

    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_ERASE  = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    localparam int SCAN_GROUP      = 16;
    localparam int SCAN_GROUP_BITS = 4;

    typedef struct packed {
        logic [1:0]                mode;
        logic                      at_tail;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] found_index;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic ers;
        logic fnd;
    } t_cell_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_res;

endpackage

// ===== sv/olie_stream_if.sv =====
// ----------------------------------------------------------------------------
// olie_stream_if: valid/ready channel
// One transfer happens at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface olie_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== sv/ordered_list_insert_erase_find.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find: ordered word list with positional insert,
// erase and first-match find
// A row of cells holds the list; insert and erase shift the cells at and behind
// the position at once, and find registers a match flag per cell and then searches the flags.
//
//   Port      Dir  Payload  Transfer
//   i_req     in   t_req    one operation
//   o_rsp     out  t_rsp    status, found index and count for each operation
//
// Insert and erase finish in the cycle of their transfer; their result is
// queued at that edge. A find registers the match flags at its transfer, and the
// search unit then walks them in 16-entry groups up to the first match or the end
// of the list (at most ceil(CAPACITY/16) groups). A two-entry result queue lets new
// operations in while results wait; i_req stalls only when it is full or a
// find is in progress. Reset empties the list at once; entries need no clearing.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_find import olie_pkg::*; #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    olie_stream_if.sink         i_req,
    olie_stream_if.source       o_rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int NG   = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int SIW  = GW + SCAN_GROUP_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIND = 1'b1;

    t_req                        w_req;
    logic                        w_acc;
    logic [DATA_WIDTH+VALUE_W-1:0] w_ext;
    logic [DATA_WIDTH-1:0]       w_word;
    logic [CMPW-1:0]             w_n;
    logic [CMPW-1:0]             w_pos;
    logic [CMPW-1:0]             w_ins_p;
    logic [CMPW-1:0]             w_ers_p;
    logic [CMPW-1:0]             w_p;
    logic [1:0]                  w_status;
    logic [CW-1:0]               n_count;
    logic                        w_ins_ok;
    logic                        w_ers_ok;
    logic                        w_is_find;
    t_cell_ctl                   w_ctl;

    logic                        r_state;
    logic [CW-1:0]               r_count;

    logic [DATA_WIDTH-1:0]       w_entry [CAPACITY];
    logic [CAPACITY-1:0]         w_match;
    t_scan_res                   w_scan;
    logic [SIW-1:0]              w_scan_idx;
    logic [SIW+INDEX_W-1:0]      w_idx_wide;
    logic [CW+COUNT_W-1:0]       w_cnt_wide;

    t_rsp                        r_q [2];
    logic                        r_wr;
    logic                        r_rd;
    logic [1:0]                  r_num;
    logic                        w_push;
    logic                        w_pop;
    t_rsp                        w_push_data;

    assign w_req       = i_req.payload;
    assign i_req.ready = (r_state == ST_IDLE) && (r_num != 2'd2);
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_ext   = {{DATA_WIDTH{w_req.value[VALUE_W-1]}}, w_req.value};
    assign w_word  = w_ext[DATA_WIDTH-1:0];
    assign w_n     = CMPW'(r_count);
    assign w_pos   = CMPW'(w_req.pos);
    assign w_ins_p = w_req.at_tail ? w_n : w_pos;
    assign w_ers_p = w_req.at_tail ? (w_n - CMPW'(1)) : w_pos;

    always_comb begin
        w_status  = STAT_RANGE;
        n_count   = r_count;
        w_ins_ok  = 1'b0;
        w_ers_ok  = 1'b0;
        w_is_find = 1'b0;
        w_p       = w_ins_p;
        unique case (w_req.mode)
            MODE_INSERT: begin
                if (w_ins_p > w_n) begin
                    w_status = STAT_RANGE;
                end else if (r_count == CW'(CAPACITY)) begin
                    w_status = STAT_FULL;
                end else begin
                    w_status = STAT_OK;
                    w_ins_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            MODE_ERASE: begin
                w_p = w_ers_p;
                if ((r_count == '0) || (w_ers_p >= w_n)) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_status = STAT_OK;
                    w_ers_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            MODE_FIND: begin
                w_status  = STAT_MISSING;
                w_is_find = 1'b1;
            end
            default: begin
                w_status = STAT_RANGE;
            end
        endcase
    end

    assign w_ctl.ins = w_acc && w_ins_ok;
    assign w_ctl.ers = w_acc && w_ers_ok;
    assign w_ctl.fnd = w_acc && w_is_find;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == CAPACITY - 1) ? g : g + 1;

        olie_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .CW         (CW),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pos   (w_p[IW-1:0]),
            .i_count (r_count),
            .i_word  (w_word),
            .i_left  (w_entry[LEFT]),
            .i_right (w_entry[RIGHT]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    olie_scan #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .GW       (GW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.fnd),
        .i_match (w_match),
        .i_count (r_count),
        .o_res   (w_scan),
        .o_index (w_scan_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_ctl.fnd) begin
                        r_state <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (w_scan.done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_idx_wide = {{INDEX_W{1'b0}}, w_scan_idx};
    assign w_cnt_wide = {{COUNT_W{1'b0}}, (r_state == ST_FIND) ? r_count : n_count};

    always_comb begin
        w_push_data.count = w_cnt_wide[COUNT_W-1:0];
        if (r_state == ST_FIND) begin
            w_push_data.status      = w_scan.hit ? STAT_OK : STAT_MISSING;
            w_push_data.found_index = w_scan.hit ? w_idx_wide[INDEX_W-1:0] : '0;
        end else begin
            w_push_data.status      = w_status;
            w_push_data.found_index = '0;
        end
    end

    assign w_push = (w_acc && !w_is_find) || w_scan.done;
    assign w_pop  = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_num <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_num <= r_num + 2'd1;
            end else if (!w_push && w_pop) begin
                r_num <= r_num - 2'd1;
            end
        end
    end

    assign o_rsp.valid   = (r_num != 2'd0);
    assign o_rsp.payload = r_q[r_rd];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num != 2'd3)
        else $error("result queue overfilled");

    a_find_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |-> !i_req.ready)
        else $error("input ready during a search");

    a_scan_in_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> (r_state == ST_FIND))
        else $error("search finished outside a find");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

endmodule

// ===== sv/olie_cell.sv =====
// ----------------------------------------------------------------------------
// olie_cell: one list position
// Holds one entry, takes its left or right neighbor on insert or erase,
// and registers whether it matches the search word and lies inside the list.
// ----------------------------------------------------------------------------
module olie_cell import olie_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 8,
    parameter int CW         = 9,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [IW-1:0]         i_pos,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic                  o_match
);

    localparam logic [IW-1:0] POS_ID = IW'(INDEX);
    localparam logic [CW-1:0] CNT_ID = CW'(INDEX);

    logic [DATA_WIDTH-1:0] r_entry;
    logic                  r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (POS_ID == i_pos) begin
                r_entry <= i_word;
            end else if (POS_ID > i_pos) begin
                r_entry <= i_left;
            end
        end else if (i_ctl.ers) begin
            if (POS_ID >= i_pos) begin
                r_entry <= i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.fnd) begin
            r_match <= (r_entry == i_word) && (CNT_ID < i_count);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ===== sv/olie_scan.sv =====
// ----------------------------------------------------------------------------
// olie_scan: first-match search over the cell match flags
// Walks the flags one group per cycle from the front and stops at the first
// set flag or at the group that holds the end of the list.
// ----------------------------------------------------------------------------
module olie_scan import olie_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int CW       = 9,
    parameter int GW       = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [CAPACITY-1:0]          i_match,
    input  logic [CW-1:0]                i_count,
    output t_scan_res                    o_res,
    output logic [GW+SCAN_GROUP_BITS-1:0] o_index
);

    localparam int NG   = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int PADW = NG * SCAN_GROUP;
    localparam int BW   = (CW > GW + SCAN_GROUP_BITS + 1) ? CW : GW + SCAN_GROUP_BITS + 1;

    logic                       r_busy;
    logic [GW-1:0]              r_group;
    logic [PADW-1:0]            w_pad;
    logic [SCAN_GROUP-1:0]      w_bits;
    logic [SCAN_GROUP_BITS-1:0] w_low;
    logic [BW-1:0]              w_next_base;
    logic                       w_any;
    logic                       w_last;

    assign w_pad  = PADW'(i_match);
    assign w_bits = w_pad[r_group*SCAN_GROUP +: SCAN_GROUP];
    assign w_any  = |w_bits;

    always_comb begin
        w_low = '0;
        for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
            if (w_bits[k]) begin
                w_low = SCAN_GROUP_BITS'(k);
            end
        end
    end

    assign w_next_base = (BW'(r_group) + BW'(1)) << SCAN_GROUP_BITS;
    assign w_last      = w_next_base >= BW'(i_count);

    assign o_res.done = r_busy && (w_any || w_last);
    assign o_res.hit  = r_busy && w_any;
    assign o_index    = {r_group, w_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_group <= '0;
        end else if (r_busy) begin
            if (w_any || w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_group <= r_group + GW'(1);
            end
        end
    end

endmodule

// ===== tb/sv/tb_ordered_list_insert_erase_find.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_erase_find: self-checking bench of the ordered list
// A directed opening covers the empty edge, bad positions, front and
// back push and pop and the unused mode; phases of random operations then fill,
// churn and drain the list while both channels stall at random. A tracker
// keeps a copy of the list, predicts every reply and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_insert_erase_find;
    import olie_pkg::*;

    localparam int CAPACITY      = 256;
    localparam int DATA_WIDTH    = 32;
    localparam int RANDOM_OPS    = 1900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class list_tracker;
        logic [VALUE_W-1:0] words [CAPACITY];
        int unsigned        n_entries;
        t_rsp               pending_replies [$];
        int unsigned        errors;

        function new();
            n_entries = 0;
            errors    = 0;
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void accept_op(input t_req r);
            t_rsp        e;
            int unsigned p;
            e = '0;
            e.status = STAT_OK;
            case (r.mode)
                MODE_INSERT: begin
                    p = r.at_tail ? n_entries : r.pos;
                    if (p > n_entries) begin
                        e.status = STAT_RANGE;
                    end else if (n_entries >= CAPACITY) begin
                        e.status = STAT_FULL;
                    end else begin
                        for (int i = n_entries; i > p; i--) words[i] = words[i-1];
                        words[p] = r.value;
                        n_entries++;
                    end
                end
                MODE_ERASE: begin
                    p = r.at_tail ? n_entries - 1 : r.pos;
                    if (n_entries == 0 || p >= n_entries) begin
                        e.status = STAT_RANGE;
                    end else begin
                        for (int i = p + 1; i < n_entries; i++) words[i-1] = words[i];
                        n_entries--;
                    end
                end
                MODE_FIND: begin
                    e.status = STAT_MISSING;
                    for (int i = 0; i < n_entries; i++) begin
                        if (words[i] == r.value) begin
                            e.status      = STAT_OK;
                            e.found_index = INDEX_W'(i);
                            break;
                        end
                    end
                end
                default: begin
                    e.status = STAT_RANGE;
                end
            endcase
            e.count = COUNT_W'(n_entries);
            pending_replies.push_back(e);
        endfunction

        task check_reply(input t_rsp got);
            t_rsp want;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply %p with nothing outstanding", got));
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.found_index !== want.found_index)
                    report($sformatf("found_index %0d, expected %0d",
                                     got.found_index, want.found_index));
                if (got.count !== want.count)
                    report($sformatf("count %0d, expected %0d", got.count, want.count));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic gaps_on;
    logic long_hold_req;
    int   cycle_count;

    list_tracker tracker;

    olie_stream_if #(.t_payload(t_req)) req_if ();
    olie_stream_if #(.t_payload(t_rsp)) rsp_if ();

    ordered_list_insert_erase_find #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            tracker.check_reply(rsp_if.payload);
        end
    end

    initial begin
        int hold_left;
        hold_left     = 0;
        rsp_if.ready  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end else if (hold_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 8);
            end
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    task automatic send_op(input logic [1:0] mode, input logic at_tail,
                           input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] value);
        t_req r;
        r.mode    = mode;
        r.at_tail = at_tail;
        r.pos     = pos;
        r.value   = value;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req_if.valid   = 1'b1;
        req_if.payload = r;
        do @(posedge clk); while (!req_if.ready);
        tracker.accept_op(r);
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                v = $urandom_range(0, 15);
                return v - 8;
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op(input int insert_weight, input int erase_weight);
        logic [1:0]         mode;
        logic               at_tail;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int                 roll;
        int                 n;
        n       = tracker.n_entries;
        roll    = $urandom_range(0, 99);
        at_tail = ($urandom_range(0, 3) == 0);
        value   = pick_value();
        pos     = '0;
        if (roll < insert_weight) begin
            mode = MODE_INSERT;
            pos  = POS_W'($urandom_range(0, n));
        end else if (roll < insert_weight + erase_weight) begin
            mode = MODE_ERASE;
            pos  = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
        end else if (roll < 98) begin
            mode = MODE_FIND;
            if (n > 0 && $urandom_range(0, 2) != 0) value = tracker.words[$urandom_range(0, n - 1)];
        end else begin
            mode = MODE_UNUSED;
        end
        if (at_tail) begin
            pos = POS_W'($urandom_range(0, 511));
        end else if ($urandom_range(0, 19) == 0) begin
            pos = POS_W'($urandom_range(n, 511));
        end
        send_op(mode, at_tail, pos, value);
    endtask

    initial begin
        int phase;
        int insert_w [5];
        int erase_w  [5];
        insert_w       = '{75, 55, 10, 45, 60};
        erase_w        = '{10, 30, 75, 40, 30};
        tracker        = new();
        cycle_count    = 0;
        gaps_on        = 1'b1;
        long_hold_req  = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_op(MODE_ERASE,  1'b0, 9'd0,   32'h0000_0000);
        send_op(MODE_ERASE,  1'b1, 9'd0,   32'h0000_0000);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'h0000_0000);
        send_op(MODE_INSERT, 1'b0, 9'd1,   32'h0000_0001);
        send_op(MODE_INSERT, 1'b1, 9'h1FF, 32'h7FFF_FFFF);
        send_op(MODE_INSERT, 1'b0, 9'd0,   32'h8000_0000);
        send_op(MODE_INSERT, 1'b0, 9'd1,   32'hFFFF_FFFF);
        send_op(MODE_INSERT, 1'b0, 9'd3,   32'h0000_0000);
        send_op(MODE_INSERT, 1'b0, 9'd5,   32'h0000_0002);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'hFFFF_FFFF);
        send_op(MODE_FIND,   1'b1, 9'h100, 32'h0000_0000);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'h7FFF_FFFF);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'h1234_5678);
        send_op(MODE_UNUSED, 1'b0, 9'd0,   32'h0000_0005);
        send_op(MODE_INSERT, 1'b0, 9'd2,   32'h0000_0005);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'h0000_0005);
        send_op(MODE_ERASE,  1'b0, 9'd5,   32'h0000_0000);
        send_op(MODE_ERASE,  1'b0, 9'h100, 32'h0000_0000);
        send_op(MODE_ERASE,  1'b0, 9'd0,   32'h0000_0000);
        send_op(MODE_ERASE,  1'b1, 9'h0AA, 32'h0000_0000);
        send_op(MODE_FIND,   1'b0, 9'd0,   32'h0000_0000);
        send_op(MODE_INSERT, 1'b1, 9'h100, 32'h5555_5555);
        send_op(MODE_INSERT, 1'b0, 9'd0,   32'hAAAA_AAAA);
        send_op(MODE_ERASE,  1'b0, 9'd1,   32'h0000_0000);
        send_op(MODE_ERASE,  1'b0, 9'd0,   32'h0000_0000);

        for (int k = 0; k < RANDOM_OPS; k++) begin
            phase   = (k * 5) / RANDOM_OPS;
            gaps_on = !((k >= 1000 && k < 1200) || k >= 1600);
            if (k == 450) long_hold_req = 1'b1;
            send_random_op(insert_w[phase], erase_w[phase]);
        end
        req_if.valid = 1'b0;

        while (tracker.pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
